// ===== rtl/core/ptdff_pkg.sv =====
// ----------------------------------------------------------------------------
// ptdff_pkg
// Types, constants and helpers shared by the T/D flip-flop block.
// ----------------------------------------------------------------------------
package ptdff_pkg;

  localparam int CHANNELS    = 16;
  localparam int CH_BITS     = 4;
  localparam int SAMPLE_BITS = 16;
  localparam int CFG_BITS    = 16;
  localparam int IDX_BITS    = 3;
  localparam int ADDR_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [IDX_BITS-1:0] {
    REG_DATA_MODE      = 3'd0,
    REG_ENABLE_GATE    = 3'd1,
    REG_HIGH_ENABLES   = 3'd2,
    REG_UNDEF_OUTPUT   = 3'd3,
    REG_GATE_THRESHOLD = 3'd4,
    REG_TRIGGER_LOW    = 3'd5,
    REG_TRIGGER_HIGH   = 3'd6,
    REG_PULSE_TICKS    = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    UNDEF_HOLD = 3'd0,
    UNDEF_LL   = 3'd1,
    UNDEF_HL   = 3'd2,
    UNDEF_LH   = 3'd3,
    UNDEF_HH   = 3'd4
  } undef_out_e;

  localparam int CONN_TD     = 0;
  localparam int CONN_CLOCK  = 1;
  localparam int CONN_SET    = 2;
  localparam int CONN_RESET  = 3;
  localparam int CONN_ENABLE = 4;

  typedef struct packed {
    logic [CH_BITS-1:0]            channel;
    logic                          tick_start;
    logic signed [SAMPLE_BITS-1:0] enable_sample;
    logic signed [SAMPLE_BITS-1:0] td_sample;
    logic signed [SAMPLE_BITS-1:0] clock_sample;
    logic signed [SAMPLE_BITS-1:0] set_sample;
    logic signed [SAMPLE_BITS-1:0] reset_sample;
    logic                          set_button;
    logic                          reset_button;
    logic [4:0]                    connected_mask;
  } in_item_t;

  typedef struct packed {
    logic q_level;
    logic q_inverted_level;
    logic outputs_updated;
    logic changed_pulse;
    logic is_disabled;
    logic undefined_op;
  } out_item_t;

  typedef struct packed {
    logic        q;
    logic        clk_trig;
    logic [15:0] remaining;
  } chan_entry_t;

  typedef struct packed {
    logic st;
    logic fire;
  } schmitt_t;

  function automatic schmitt_t schmitt(input logic st,
                                       input logic signed [SAMPLE_BITS-1:0] x,
                                       input logic signed [CFG_BITS-1:0] lo,
                                       input logic signed [CFG_BITS-1:0] hi);
    schmitt_t r;
    r.st   = st;
    r.fire = 1'b0;
    if (st) begin
      if (x <= lo) r.st = 1'b0;
    end else if (x >= hi) begin
      r.st   = 1'b1;
      r.fire = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/ptdff_in_if.sv =====
// ----------------------------------------------------------------------------
// ptdff_in_if
// Valid/ready channel carrying one channel request per item.
// ----------------------------------------------------------------------------
interface ptdff_in_if import ptdff_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ptdff_out_if.sv =====
// ----------------------------------------------------------------------------
// ptdff_out_if
// Valid/ready channel carrying one result per item.
// ----------------------------------------------------------------------------
interface ptdff_out_if import ptdff_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/poly_td_flip_flop_set_reset.sv =====
// ----------------------------------------------------------------------------
// poly_td_flip_flop_set_reset
// Polyphonic T/D flip-flop with set, reset and enable; per-channel state
// held in a synchronous memory with read-modify-write.
//
//   port    dir  handshake    carries
//   in_i    in   valid/ready  one channel request per tick
//   out_o   out  valid/ready  Q, !Q, update, pulse, disabled, undefined
//   cfg_*   in   write enable register index and data
//
// One request per cycle while the output is not stalled; stages are memory read,
// then update and output register. The per-channel memory read port is registered;
// a forwarding register covers back-to-back requests to the same channel.
// Reset clears per-channel valid bits at once, so no clearing pass is needed.
// A stalled output holds the update stage; input waits once that stage is full.
// ----------------------------------------------------------------------------
module poly_td_flip_flop_set_reset import ptdff_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  ptdff_in_if.sink            in_i,
  ptdff_out_if.source         out_o,
  input  logic                cfg_we_i,
  input  logic [IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0] cfg_data_i
);

  logic                       data_mode_q, gate_mode_q, high_en_q;
  logic [2:0]                 undef_out_q;
  logic signed [CFG_BITS-1:0] gate_thr_q, trig_lo_q, trig_hi_q;
  logic [15:0]                pulse_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_mode_q   <= 1'b0;
      gate_mode_q   <= 1'b1;
      high_en_q     <= 1'b0;
      undef_out_q   <= 3'd0;
      gate_thr_q    <= 16'sd6553;
      trig_lo_q     <= 16'sd2730;
      trig_hi_q     <= 16'sd6553;
      pulse_ticks_q <= 16'd48;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_DATA_MODE:      data_mode_q   <= cfg_data_i[0];
        REG_ENABLE_GATE:    gate_mode_q   <= cfg_data_i[0];
        REG_HIGH_ENABLES:   high_en_q     <= cfg_data_i[0];
        REG_UNDEF_OUTPUT:   undef_out_q   <= cfg_data_i[2:0];
        REG_GATE_THRESHOLD: gate_thr_q    <= cfg_data_i;
        REG_TRIGGER_LOW:    trig_lo_q     <= cfg_data_i;
        REG_TRIGGER_HIGH:   trig_hi_q     <= cfg_data_i;
        REG_PULSE_TICKS:    pulse_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s1_q, ov_q;
  logic adv, in_acc, fire1;

  assign adv       = !ov_q || out_o.ready;
  assign fire1     = s1_q && adv;
  assign in_i.ready = !s1_q || adv;
  assign in_acc    = in_i.valid && in_i.ready;

  // per-channel memory
  chan_entry_t               mem [CHANNELS];
  chan_entry_t               rd_q;
  logic [CHANNELS-1:0]       vld_q;
  logic                      wr_en;
  chan_entry_t               wr_data;
  logic [ADDR_BITS-1:0]      in_addr, s1_addr;

  in_item_t    s1_item_q;
  logic        s1_hit_q;
  chan_entry_t s1_fwd_q;

  assign in_addr = ADDR_BITS'(in_i.data.channel % CHANNELS);
  assign s1_addr = ADDR_BITS'(s1_item_q.channel % CHANNELS);

  always_ff @(posedge clk_i) begin
    if (in_acc) rd_q <= mem[in_addr];
    if (wr_en) mem[s1_addr] <= wr_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[s1_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_i.data;
      s1_hit_q  <= wr_en && (s1_addr == in_addr);
      s1_fwd_q  <= wr_data;
    end
  end

  // update stage
  logic        en_trig_q, en_trig_d, dis_q, dis_d;
  chan_entry_t entry;
  out_item_t   res;

  always_comb begin
    logic signed [SAMPLE_BITS-1:0] td_v, clk_v;
    logic                          set_g, rst_g, q, qinv, upd, undef;
    schmitt_t                      es, cs;

    entry = s1_hit_q ? s1_fwd_q : (vld_q[s1_addr] ? rd_q : '0);

    en_trig_d = en_trig_q;
    dis_d     = dis_q;
    es        = schmitt(en_trig_q, s1_item_q.enable_sample, trig_lo_q, trig_hi_q);
    if (s1_item_q.tick_start) begin
      if (s1_item_q.connected_mask[CONN_ENABLE]) begin
        if (!gate_mode_q) begin
          en_trig_d = es.st;
          if (es.fire) dis_d = !dis_q;
        end else begin
          dis_d = (s1_item_q.enable_sample >= gate_thr_q) ? !high_en_q : high_en_q;
        end
      end else begin
        dis_d = 1'b0;
      end
    end

    set_g = s1_item_q.set_button ||
            (s1_item_q.connected_mask[CONN_SET] && s1_item_q.set_sample >= gate_thr_q);
    rst_g = s1_item_q.reset_button ||
            (s1_item_q.connected_mask[CONN_RESET] && s1_item_q.reset_sample >= gate_thr_q);
    td_v  = s1_item_q.connected_mask[CONN_TD] ? s1_item_q.td_sample : '0;
    clk_v = s1_item_q.connected_mask[CONN_CLOCK] ? s1_item_q.clock_sample : td_v;
    cs    = schmitt(entry.clk_trig, clk_v, trig_lo_q, trig_hi_q);

    wr_data = entry;
    q       = entry.q;
    qinv    = 1'b0;
    upd     = 1'b1;
    undef   = 1'b0;

    if (set_g && rst_g) begin
      undef = 1'b1;
      case (undef_out_e'(undef_out_q))
        UNDEF_LL: begin q = 1'b0; qinv = 1'b0; end
        UNDEF_HL: begin q = 1'b1; qinv = 1'b0; end
        UNDEF_LH: begin q = 1'b0; qinv = 1'b1; end
        UNDEF_HH: begin q = 1'b1; qinv = 1'b1; end
        default:  upd = 1'b0;
      endcase
    end else if (set_g) begin
      q = 1'b1;
    end else if (rst_g) begin
      q = 1'b0;
    end else begin
      wr_data.clk_trig = cs.st;
      if (cs.fire) begin
        if (!data_mode_q) begin
          if (td_v >= gate_thr_q) q = !entry.q;
        end else begin
          q = (td_v >= gate_thr_q);
        end
      end
    end
    if (!undef || !upd) qinv = !q;

    wr_data.q = q;
    if (entry.remaining != '0) wr_data.remaining = entry.remaining - 16'd1;
    else if (entry.q != q)     wr_data.remaining = pulse_ticks_q;

    if (dis_d) begin
      res.q_level          = entry.q;
      res.q_inverted_level = !entry.q;
      res.outputs_updated  = 1'b0;
      res.changed_pulse    = (entry.remaining != '0);
      res.is_disabled      = 1'b1;
      res.undefined_op     = 1'b0;
    end else begin
      res.q_level          = q;
      res.q_inverted_level = qinv;
      res.outputs_updated  = upd;
      res.changed_pulse    = (wr_data.remaining != '0);
      res.is_disabled      = 1'b0;
      res.undefined_op     = undef;
    end

    wr_en = fire1 && !dis_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_trig_q <= 1'b0;
      dis_q     <= 1'b0;
    end else if (fire1) begin
      en_trig_q <= en_trig_d;
      dis_q     <= dis_d;
    end
  end

  // output register
  out_item_t od_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire1) od_q <= res;
  end

  assign out_o.valid = ov_q;
  assign out_o.data  = od_q;

endmodule

// ===== rtl/core/ptdff_chk.sv =====
// ----------------------------------------------------------------------------
// ptdff_chk
// Port-level checks on the result channel of the flip-flop block.
// ----------------------------------------------------------------------------
module ptdff_chk import ptdff_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result dropped or changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.is_disabled |->
      !out_data_i.outputs_updated && !out_data_i.undefined_op)
    else $error("disabled result claims update or undefined operation");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.undefined_op |->
      out_data_i.q_inverted_level != out_data_i.q_level)
    else $error("inverted output not complementary");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.outputs_updated && !out_data_i.is_disabled |->
      out_data_i.undefined_op)
    else $error("held outputs without undefined operation");

endmodule

bind poly_td_flip_flop_set_reset ptdff_chk u_ptdff_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
